// ===== hdl/csca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csca_pkg: shared types and constants
// Opcodes, register indices, sequencer states and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package csca_pkg;

  localparam int FFT_SIZE_DEF = 64;
  localparam int MAX_RX_DEF   = 4;
  localparam int ACC_W        = 48;
  localparam int SUM_W        = 52;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_PEAK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_ACTIVE = 3'd0,
    REG_ROT0   = 3'd1,
    REG_ROT1   = 3'd2,
    REG_ROT2   = 3'd3,
    REG_ROT3   = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROT,
    S_PROD,
    S_RD,
    S_RD_OUT,
    S_CLEAR,
    S_PK_RD,
    S_PK_WAIT,
    S_PK_SQRT,
    S_PK_BIN,
    S_PK_OUT
  } state_t;

  // quarter-wave sine, round(32767*sin(i*pi/64))
  function automatic logic [15:0] qsin(input logic [5:0] i);
    logic [15:0] v;
    case (i)
      6'd0: v = 16'd0;       6'd1: v = 16'd1608;    6'd2: v = 16'd3212;
      6'd3: v = 16'd4808;    6'd4: v = 16'd6393;    6'd5: v = 16'd7962;
      6'd6: v = 16'd9512;    6'd7: v = 16'd11039;   6'd8: v = 16'd12539;
      6'd9: v = 16'd14010;   6'd10: v = 16'd15446;  6'd11: v = 16'd16846;
      6'd12: v = 16'd18204;  6'd13: v = 16'd19519;  6'd14: v = 16'd20787;
      6'd15: v = 16'd22005;  6'd16: v = 16'd23170;  6'd17: v = 16'd24279;
      6'd18: v = 16'd25329;  6'd19: v = 16'd26319;  6'd20: v = 16'd27245;
      6'd21: v = 16'd28105;  6'd22: v = 16'd28898;  6'd23: v = 16'd29621;
      6'd24: v = 16'd30273;  6'd25: v = 16'd30852;  6'd26: v = 16'd31356;
      6'd27: v = 16'd31785;  6'd28: v = 16'd32137;  6'd29: v = 16'd32412;
      6'd30: v = 16'd32609;  6'd31: v = 16'd32728;
      default: v = 16'd32767;
    endcase
    return v;
  endfunction

  // quarter wave with linear interpolation, a in 0..16384
  function automatic logic [15:0] quarter(input logic [14:0] a);
    logic [5:0]  i;
    logic [8:0]  f;
    logic [15:0] d;
    logic [24:0] pr;
    i = a[14:9];
    f = a[8:0];
    if (i >= 6'd32) return qsin(6'd32);
    d = qsin(i + 6'd1) - qsin(i);
    pr = 25'(d) * 25'(f);
    return qsin(i) + pr[24:9];
  endfunction

  function automatic logic signed [16:0] sine(input logic [15:0] p);
    logic [15:0] v;
    v = p[14] ? quarter(15'd16384 - 15'(p[13:0])) : quarter(15'(p[13:0]));
    return p[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

// ===== hdl/cross_spectral_covariance_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_spectral_covariance_accumulator: per-bin covariance store
// Rotates receiver bin values and accumulates the cross products per bin.
// ----------------------------------------------------------------------------
// Usage:
//  Raise start with opcode and payload; the item is taken when busy is low.
//  busy stays high until the item's work is over.
//  Accumulate: each receiver passes one shared rotator (phase, sine and
//   cosine, rotate), then each of the n*n products is added in a
//   read-modify-write through one complex MAC.
//  Read: busy through S_RD and S_RD_OUT, result strobed on valid as busy falls, kind 0.
//  Clear: one store entry a cycle, all FFT_SIZE*MAX_RECEIVERS^2 entries.
//  Peak: each off-diagonal entry passes the serial square-root unit; result
//   strobed with kind 1. Fewer than two receivers: result without any root.
//  Reset: a clearing pass over all FFT_SIZE*MAX_RECEIVERS^2 entries runs
//   after reset with busy high; configuration writes are taken at any time.
//  Results cannot be stalled: valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module cross_spectral_covariance_accumulator #(
  parameter int FFT_SIZE      = csca_pkg::FFT_SIZE_DEF,
  parameter int MAX_RECEIVERS = csca_pkg::MAX_RX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [5:0]  bin,
  input  logic [1:0]  row,
  input  logic [1:0]  col,
  input  logic signed [15:0] rx0_re,
  input  logic signed [15:0] rx0_im,
  input  logic signed [15:0] rx1_re,
  input  logic signed [15:0] rx1_im,
  input  logic signed [15:0] rx2_re,
  input  logic signed [15:0] rx2_im,
  input  logic signed [15:0] rx3_re,
  input  logic signed [15:0] rx3_im,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        valid,
  output logic signed [csca_pkg::ACC_W-1:0] entry_re,
  output logic signed [csca_pkg::ACC_W-1:0] entry_im,
  output logic [5:0]  peak_bin,
  output logic [csca_pkg::SUM_W-1:0] peak_sum,
  output logic        kind
);
  import csca_pkg::*;

  localparam int BW    = $clog2(FFT_SIZE);
  localparam int RXW   = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1;
  localparam int DEPTH = FFT_SIZE * MAX_RECEIVERS * MAX_RECEIVERS;
  localparam int AW    = $clog2(DEPTH);

  // configuration
  logic [2:0]  active_receivers;
  logic [31:0] rot [4];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_receivers <= 3'd4;
      for (int i = 0; i < 4; i++) rot[i] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACTIVE: active_receivers <= cfg_data[2:0];
        REG_ROT0:   rot[0] <= cfg_data;
        REG_ROT1:   rot[1] <= cfg_data;
        REG_ROT2:   rot[2] <= cfg_data;
        REG_ROT3:   rot[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // covariance memory: {re, im}
  logic [2*ACC_W-1:0] mem [DEPTH];
  logic [2*ACC_W-1:0] rd_data;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [2*ACC_W-1:0] wr_data;
  logic               wr_en;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  state_t state, state_next;

  // item registers
  logic [1:0]       op_q;
  logic [BW-1:0]    bin_q;
  logic [1:0]       row_q, col_q;
  logic signed [15:0] xr [4];
  logic signed [15:0] xi [4];
  logic signed [16:0] yr [4];
  logic signed [16:0] yi [4];
  logic [2:0]       n;
  logic [RXW:0]     ri, si;     // loop indices, room for the count
  logic [AW:0]      caddr;
  logic [1:0]       sub;
  logic [SUM_W:0]   sum, best;
  logic [BW-1:0]    best_bin;
  logic             out_kind;

  // real part computed the cycle before the write
  logic signed [34:0] prod_re_q;
  logic [BW-1:0] best_bin_i;   // bin under scan
  logic pk_last;
  logic pk_pair_last;

  logic [2:0] n_eff;
  assign n_eff = (active_receivers > 3'(MAX_RECEIVERS)) ? 3'(MAX_RECEIVERS)
                                                        : active_receivers;

  // shared rotator on receiver ri: phase, then sine and cosine, then rotate
  logic signed [BW:0]  k;
  logic [15:0] ph, ph_q;
  logic signed [16:0] sn, cs, sn_q, cs_q;
  logic signed [33:0] t_re, t_im;
  logic [1:0] rsel;
  assign rsel = ri[1:0];
  assign k  = bin_q[BW-1] ? $signed({1'b1, bin_q}) : $signed({1'b0, bin_q});
  assign ph = rot[rsel][31:16] + 16'(rot[rsel][15:0] * 16'(k));
  assign sn = sine(ph_q);
  assign cs = sine(ph_q + 16'd16384);
  assign t_re = xr[rsel] * cs_q - xi[rsel] * sn_q + 34'sd16384;
  assign t_im = xr[rsel] * sn_q + xi[rsel] * cs_q + 34'sd16384;

  // shared complex MAC, one part, real or imaginary, per cycle
  logic [1:0] ra, sa;
  logic signed [34:0] prod;
  assign ra = ri[1:0];
  assign sa = si[1:0];
  assign prod = sub[0] ? (yi[ra] * yr[sa] - yr[ra] * yi[sa])
                       : (yr[ra] * yr[sa] + yi[ra] * yi[sa]);

  logic [AW-1:0] eaddr;
  assign eaddr = AW'((32'(bin_q) * MAX_RECEIVERS + 32'(ra)) * MAX_RECEIVERS + 32'(sa));

  // square root
  logic sq_go, sq_done;
  logic [ACC_W:0] sq_root;
  csca_sqrt u_sqrt (
    .clk(clk), .rst(rst), .go(sq_go),
    .re(rd_data[2*ACC_W-1:ACC_W]), .im(rd_data[ACC_W-1:0]),
    .done(sq_done), .root(sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  logic last_pair;
  assign last_pair = (32'(si) + 1 >= 32'(n)) && (32'(ri) + 1 >= 32'(n));

  // last off-diagonal pair of a bin is (n-1, n-2)
  assign pk_pair_last = (32'(ri) + 1 >= 32'(n)) && (32'(si) + 2 >= 32'(n));
  assign pk_last = pk_pair_last && (32'(best_bin_i) + 1 >= FFT_SIZE);

  // sequencer
  always_comb begin
    state_next = state;
    busy    = 1'b1;
    wr_en   = 1'b0;
    wr_addr = eaddr;
    wr_data = rd_data;
    rd_addr = eaddr;
    sq_go   = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (op_t'(opcode))
            OP_ACC:   state_next = (n_eff == 3'd0) ? S_IDLE : S_ROT;
            OP_READ:  state_next = S_RD;
            OP_CLEAR: state_next = S_CLEAR;
            // fewer than two receivers: no off-diagonal terms
            default:  state_next = (n_eff < 3'd2) ? S_PK_OUT : S_PK_RD;
          endcase
        end
      end
      S_ROT: if (sub == 2'd2 && 32'(ri) + 1 >= 32'(n)) state_next = S_PROD;
      S_PROD: begin
        // sub 0: read issued; 1: data back, write both parts
        if (sub == 2'd1) begin
          wr_en   = 1'b1;
          wr_data = {rd_data[2*ACC_W-1:ACC_W] + ACC_W'(prod_re_q),
                     rd_data[ACC_W-1:0] + ACC_W'(prod)};
          if (last_pair) state_next = S_IDLE;
        end
      end
      S_RD: begin
        rd_addr = AW'((32'(bin_q) * MAX_RECEIVERS + 32'(row_q)) * MAX_RECEIVERS
                      + 32'(col_q));
        state_next = S_RD_OUT;
      end
      S_RD_OUT: state_next = S_IDLE;
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = caddr[AW-1:0];
        wr_data = '0;
        if (32'(caddr) + 1 >= DEPTH) state_next = S_IDLE;
      end
      S_PK_RD: begin
        rd_addr = AW'((32'(best_bin_i) * MAX_RECEIVERS + 32'(ra)) * MAX_RECEIVERS
                      + 32'(sa));
        state_next = S_PK_WAIT;
      end
      S_PK_WAIT: begin
        sq_go = 1'b1;
        state_next = S_PK_SQRT;
      end
      S_PK_SQRT: if (sq_done) state_next = S_PK_BIN;
      S_PK_BIN: state_next = pk_last ? S_PK_OUT : S_PK_RD;
      S_PK_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // off-diagonal stepping for peak: skip r == s and empty counts
  function automatic logic [2*RXW+1:0] next_pair(input logic [RXW:0] r,
                                                 input logic [RXW:0] s,
                                                 input logic [2:0] cnt);
    logic [RXW:0] nr, ns;
    nr = r; ns = s;
    for (int j = 0; j < 2; j++) begin
      if (32'(ns) + 1 >= 32'(cnt)) begin
        ns = '0; nr = nr + 1'b1;
      end else begin
        ns = ns + 1'b1;
      end
      if (nr != ns) break;
    end
    return {nr, ns};
  endfunction

  logic [RXW:0] pr_r, pr_s;
  assign {pr_r, pr_s} = next_pair(ri, si, n);

  logic [SUM_W:0] sum_add;
  assign sum_add = sum + (SUM_W+1)'(sq_root);

  always_ff @(posedge clk) begin
    if (rst) begin
      caddr <= '0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          op_q  <= opcode;
          bin_q <= BW'(bin);
          row_q <= row;
          col_q <= col;
          xr[0] <= rx0_re; xi[0] <= rx0_im;
          xr[1] <= rx1_re; xi[1] <= rx1_im;
          xr[2] <= rx2_re; xi[2] <= rx2_im;
          xr[3] <= rx3_re; xi[3] <= rx3_im;
          n     <= n_eff;
          ri    <= '0;
          si    <= (n_eff >= 3'd2 && op_t'(opcode) == OP_PEAK) ? (RXW+1)'(1) : '0;
          sub   <= '0;
          caddr <= '0;
          sum   <= '0;
          best  <= '0;
          best_bin   <= '0;
          best_bin_i <= '0;
        end
        S_ROT: begin
          case (sub)
            2'd0: begin
              ph_q <= ph;
              sub  <= 2'd1;
            end
            2'd1: begin
              sn_q <= sn;
              cs_q <= cs;
              sub  <= 2'd2;
            end
            default: begin
              yr[rsel] <= 17'(t_re >>> 15);
              yi[rsel] <= 17'(t_im >>> 15);
              sub <= 2'd0;
              if (32'(ri) + 1 >= 32'(n)) ri <= '0;
              else ri <= ri + 1'b1;
            end
          endcase
        end
        S_PROD: begin
          if (sub == 2'd0) begin
            prod_re_q <= prod;
            sub <= 2'd1;
          end else begin
            sub <= 2'd0;
            if (32'(si) + 1 >= 32'(n)) begin
              si <= '0; ri <= ri + 1'b1;
            end else si <= si + 1'b1;
          end
        end
        S_RD_OUT: begin
          valid    <= 1'b1;
          kind     <= 1'b0;
          entry_re <= rd_data[2*ACC_W-1:ACC_W];
          entry_im <= rd_data[ACC_W-1:0];
          peak_bin <= '0;
          peak_sum <= '0;
        end
        S_CLEAR: caddr <= caddr + 1'b1;
        S_PK_SQRT: if (sq_done) sum <= sum_add;
        S_PK_BIN: begin
          if (pk_pair_last) begin
            if (((sum > (SUM_W+1)'({SUM_W{1'b1}})) ? (SUM_W+1)'({SUM_W{1'b1}}) : sum)
                > best) begin
              best     <= (sum > (SUM_W+1)'({SUM_W{1'b1}})) ?
                          (SUM_W+1)'({SUM_W{1'b1}}) : sum;
              best_bin <= best_bin_i;
            end
            sum <= '0;
            best_bin_i <= best_bin_i + 1'b1;
            ri <= '0;
            si <= (RXW+1)'(1);
          end else begin
            ri <= pr_r;
            si <= pr_s;
          end
        end
        S_PK_OUT: begin
          valid    <= 1'b1;
          kind     <= 1'b1;
          entry_re <= '0;
          entry_im <= '0;
          peak_bin <= 6'(best_bin);
          peak_sum <= best[SUM_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // op_q kept for debug visibility of the running item
  logic op_is_peak;
  assign op_is_peak = (op_q == OP_PEAK);

`ifndef NO_ASSERTIONS
  a_valid_pulse: assert property (@(posedge clk) disable iff (rst) valid |=> !valid)
    else $error("result strobe held");
  a_busy_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_READ) |=> busy)
    else $error("read not taken");
  a_peak_kind: assert property (@(posedge clk) disable iff (rst)
    (state == S_PK_OUT) |=> (valid && kind && op_is_peak))
    else $error("peak result missing");
`endif
endmodule

// ===== hdl/csca_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csca_sqrt: bit-serial integer square root
// floor(sqrt(re^2+im^2)) of two signed 48-bit values, one result bit a cycle.
// ----------------------------------------------------------------------------
module csca_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic signed [csca_pkg::ACC_W-1:0] re,
  input  logic signed [csca_pkg::ACC_W-1:0] im,
  output logic                              done,
  output logic [csca_pkg::ACC_W:0]          root
);
  import csca_pkg::*;

  localparam int RW = ACC_W + 1;   // 49-bit root
  localparam int QW = 2 * RW + 2;

  logic [QW-1:0]    rem;
  logic [2*RW-1:0]  num;
  logic [RW-1:0]    res;
  logic [6:0]       cnt;
  logic             busy;
  logic [ACC_W-1:0] ma, mb;
  logic [ACC_W-1:0] la, lb;     // magnitudes held from go
  logic [QW-1:0]    trial, rem_sh;
  logic             phase;      // 0: square, 1: iterate

  assign ma = re[ACC_W-1] ? ACC_W'(-re) : ACC_W'(re);
  assign mb = im[ACC_W-1] ? ACC_W'(-im) : ACC_W'(im);

  // sum of squares, built from partial products of the 24-bit halves of each operand
  logic [1:0]  sq_step;
  logic [ACC_W-1:0] opnd;
  logic [23:0] hi_p, lo_p;
  logic [47:0] pp;
  logic [2*RW-1:0] acc;

  assign opnd = sq_step[1] ? lb : la;
  assign hi_p = opnd[47:24];
  assign lo_p = opnd[23:0];

  // restoring digit step
  assign rem_sh = {rem[QW-3:0], num[2*RW-1:2*RW-2]};
  assign trial  = {res, 2'b01};

  logic [2:0] part;
  always_comb begin
    unique case (part)
      3'd0: pp = lo_p * lo_p;
      3'd1: pp = hi_p * lo_p;
      default: pp = hi_p * hi_p;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go && !busy) begin
        busy    <= 1'b1;
        phase   <= 1'b0;
        sq_step <= 2'd0;
        part    <= 3'd0;
        acc     <= '0;
        la      <= ma;
        lb      <= mb;
      end else if (busy && !phase) begin
        // sum of squares: three partial products per operand
        unique case (part)
          3'd0: acc <= acc + (2*RW)'(pp);
          3'd1: acc <= acc + ((2*RW)'(pp) << 25);
          default: acc <= acc + ((2*RW)'(pp) << 48);
        endcase
        if (part == 3'd2) begin
          part <= 3'd0;
          if (sq_step[1]) begin
            phase <= 1'b1;
            cnt   <= 7'(RW);
            rem   <= '0;
            res   <= '0;
          end
          sq_step <= 2'd2;
        end else begin
          part <= part + 3'd1;
        end
      end else if (busy) begin
        if (cnt == 7'(RW)) begin
          num <= acc;
          cnt <= cnt - 7'd1;
          rem <= '0;
        end else begin
          if (rem_sh >= trial) begin
            rem <= rem_sh - trial;
            res <= {res[RW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            res <= {res[RW-2:0], 1'b0};
          end
          num <= {num[2*RW-3:0], 2'b00};
          if (cnt == 7'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - 7'd1;
          end
        end
      end
    end
  end

  // last digit lands with done
  assign root = res;

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("sqrt done held");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("sqrt done while busy");
  a_acc_phase: assert property (@(posedge clk) disable iff (rst)
    (busy && phase) |=> (busy || done))
    else $error("sqrt dropped");
`endif
endmodule
